/* design/sbcd_pkg.sv */
// Shared types, constants and functions for the superblock checked decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbcd_pkg;

  localparam int MAGIC_LEN = 8;
  localparam int NUM_FIELDS = 17;
  localparam int FIELD_IDX_W = 5;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] POS_FIELD_FIRST = 8'd8;
  localparam logic [7:0] POS_CRC_SPAN = 8'd128;
  localparam logic [7:0] POS_LAST = 8'd131;
  localparam logic [7:0] POS_IDLE = 8'd132;

  localparam logic [FIELD_IDX_W-1:0] FIELD_LAST = FIELD_IDX_W'(NUM_FIELDS - 1);

  // register indexes on the configuration port
  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_VER_A = 2'd1;
  localparam logic [1:0] REG_VER_B = 2'd2;
  localparam logic [1:0] REG_BLK_SIZE = 2'd3;

  typedef enum logic [2:0] {
    STS_OK = 3'd0,
    STS_BAD_MAGIC = 3'd1,
    STS_BAD_CRC = 3'd2,
    STS_BAD_VERSION = 3'd3,
    STS_BAD_BLK_SIZE = 3'd4
  } sbcd_status_t;

  typedef enum logic [2:0] {
    S_RUN = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT = 3'b100
  } sbcd_state_t;

  typedef struct packed {
    logic [63:0] magic;
    logic [31:0] ver_a;
    logic [31:0] ver_b;
    logic [31:0] blk_size;
  } sbcd_cfg_t;

  typedef struct packed {
    logic take;        // input word accepted this cycle
    logic load_first;  // run the checks and load the first result
    logic load_next;   // advance to the next field
  } sbcd_cmd_t;

  typedef struct packed {
    logic last_byte;   // word being taken is the final header byte
    logic out_last;    // result held in the output register ends the run
  } sbcd_stat_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] idx;
    logic [2:0] lane;
  } sbcd_loc_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // map header offset 8..127 to field number and byte lane
  function automatic sbcd_loc_t locate(input logic [6:0] p);
    sbcd_loc_t r;
    r.lane = {1'b0, p[1:0]};
    if (p < 7'd12) begin
      r.idx = 5'd0;
    end else if (p < 7'd16) begin
      r.idx = 5'd1;
    end else if (p < 7'd24) begin
      r.idx = 5'd2;
      r.lane = p[2:0];
    end else if (p < 7'd28) begin
      r.idx = 5'd3;
    end else if (p < 7'd32) begin
      r.idx = 5'd4;
    end else begin
      r.idx = {1'b0, p[6:3]} + 5'd1;
      r.lane = p[2:0];
    end
    return r;
  endfunction

endpackage

/* design/sbcd_regs.sv */
// Configuration register file on the APB-style port.
// Depends on sbcd_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps

module sbcd_regs
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output sbcd_cfg_t   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[4:3];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic <= 64'd0;
      cfg.ver_a <= 32'd1;
      cfg.ver_b <= 32'd2;
      cfg.blk_size <= 32'd4096;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAGIC:    cfg.magic <= pwdata;
        REG_VER_A:    cfg.ver_a <= pwdata[31:0];
        REG_VER_B:    cfg.ver_b <= pwdata[31:0];
        REG_BLK_SIZE: cfg.blk_size <= pwdata[31:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAGIC:    prdata = cfg.magic;
      REG_VER_A:    prdata = {32'd0, cfg.ver_a};
      REG_VER_B:    prdata = {32'd0, cfg.ver_b};
      REG_BLK_SIZE: prdata = {32'd0, cfg.blk_size};
      default:      prdata = 64'd0;
    endcase
  end

endmodule

/* design/sbcd_dp.sv */
// Datapath: byte position, CRC, magic compare, field capture, checks and result register.
// Depends on sbcd_pkg; driven by sbcd_ctrl through command and status structs.
`timescale 1ns / 1ps

module sbcd_dp
  import sbcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  sbcd_cfg_t              cfg,
  input  sbcd_cmd_t              cmd,
  input  logic [7:0]             data_byte,
  input  logic                   block_start,
  output sbcd_stat_t             stat,
  output logic [FIELD_IDX_W-1:0] field_index,
  output logic [63:0]            field_value,
  output logic [2:0]             status,
  output logic                   last
);

  logic [7:0]  pos;
  logic [31:0] crc;
  logic [31:0] stored_crc;
  logic        magic_ok;
  logic [63:0] acc;
  logic [63:0] field_store [NUM_FIELDS];

  logic [7:0]  p_eff;
  logic [31:0] crc_base;
  logic        magic_base;
  logic        magic_hit;
  sbcd_loc_t   loc;
  logic [63:0] acc_next;
  logic [FIELD_IDX_W-1:0] next_idx;
  logic [2:0]  chk_status;
  logic [31:0] ver;
  logic [31:0] blk;

  // a start flag restarts the image at offset zero
  assign p_eff = block_start ? 8'd0 : pos;
  assign crc_base = block_start ? CRC_ONES : crc;
  assign magic_base = block_start ? 1'b1 : magic_ok;
  assign magic_hit = (cfg.magic[{p_eff[2:0], 3'b000} +: 8] == data_byte);
  assign loc = locate(p_eff[6:0]);
  assign acc_next = (loc.lane == 3'd0) ? {56'd0, data_byte}
                  : (acc | ({56'd0, data_byte} << {loc.lane, 3'b000}));
  assign next_idx = field_index + 5'd1;

  assign stat.last_byte = (p_eff == POS_LAST);
  assign stat.out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
      crc <= CRC_ONES;
      magic_ok <= 1'b1;
    end else if (cmd.take && (p_eff < POS_IDLE)) begin
      pos <= p_eff + 8'd1;
      if (p_eff < POS_CRC_SPAN) begin
        crc <= crc_byte(crc_base, data_byte);
      end else begin
        crc <= crc_base;
      end
      if (p_eff < 8'(MAGIC_LEN)) begin
        magic_ok <= magic_base & magic_hit;
      end else begin
        magic_ok <= magic_base;
      end
    end
  end

  // every lane of the stored CRC and of every field is rewritten before the check
  always_ff @(posedge clk) begin
    if (cmd.take && (p_eff >= POS_CRC_SPAN) && (p_eff <= POS_LAST)) begin
      stored_crc[{p_eff[1:0], 3'b000} +: 8] <= data_byte;
    end
    if (cmd.take && (p_eff >= POS_FIELD_FIRST) && (p_eff < POS_CRC_SPAN)) begin
      acc <= acc_next;
      field_store[loc.idx] <= acc_next;
    end
  end

  assign ver = field_store[0][31:0];
  assign blk = field_store[1][31:0];

  always_comb begin
    priority if (!magic_ok) begin
      chk_status = STS_BAD_MAGIC;
    end else if ((crc ^ CRC_ONES) != stored_crc) begin
      chk_status = STS_BAD_CRC;
    end else if ((ver != cfg.ver_a) && (ver != cfg.ver_b)) begin
      chk_status = STS_BAD_VERSION;
    end else if (blk != cfg.blk_size) begin
      chk_status = STS_BAD_BLK_SIZE;
    end else begin
      chk_status = STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (cmd.load_first) begin
      last <= (chk_status != STS_OK);
    end else if (cmd.load_next) begin
      last <= (next_idx == FIELD_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      field_index <= 5'd0;
      status <= chk_status;
      field_value <= (chk_status == STS_OK) ? field_store[0] : 64'd0;
    end else if (cmd.load_next) begin
      field_index <= next_idx;
      field_value <= field_store[next_idx];
    end
  end

endmodule

/* design/sbcd_ctrl.sv */
// Controller: sequences byte intake, the check cycle and the result run.
// Depends on sbcd_pkg; commands sbcd_dp.
`timescale 1ns / 1ps

module sbcd_ctrl
  import sbcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  sbcd_stat_t stat,
  output sbcd_cmd_t  cmd
);

  sbcd_state_t state;
  sbcd_state_t state_next;

  assign s_tready = (state == S_RUN);
  assign m_tvalid = (state == S_EMIT);

  always_comb begin
    cmd.take = s_tready & s_tvalid;
    cmd.load_first = (state == S_CHECK);
    cmd.load_next = m_tvalid & m_tready & ~stat.out_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (cmd.take && stat.last_byte) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (m_tready && stat.out_last) state_next = S_RUN;
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("intake and result run overlap");

  a_final_byte_stops_intake: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && stat.last_byte) |=> (!s_tready && !m_tvalid))
    else $error("final byte did not start the check");

  a_check_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load_first |=> m_tvalid)
    else $error("check cycle not followed by a result");

  a_run_end_resumes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && stat.out_last) |=> s_tready)
    else $error("intake not resumed after the run");

endmodule

/* design/superblock_checked_decoder.sv */
// Superblock checked decoder: takes header bytes one word per cycle while s_tvalid is
// high, then a check state, then 17 field words (or one status word) one per cycle as
// m_tready allows; intake stops from the final header byte until the last result word
// is taken.
// Synchronous reset: idle until a word flagged as block start, config at defaults.
// Depends on sbcd_pkg, sbcd_regs, sbcd_dp and sbcd_ctrl.
`timescale 1ns / 1ps

module superblock_checked_decoder
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] block_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [4:0] field_index, [68:5] field_value, [71:69] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sbcd_cfg_t              cfg;
  sbcd_cmd_t              cmd;
  sbcd_stat_t             stat;
  logic [FIELD_IDX_W-1:0] field_index;
  logic [63:0]            field_value;

  assign pready = 1'b1;
  assign m_tdata = {3'd0, field_value, field_index};

  sbcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sbcd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .block_start (s_tuser[0]),
    .stat        (stat),
    .field_index (field_index),
    .field_value (field_value),
    .status      (m_tuser),
    .last        (m_tlast)
  );

  sbcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

endmodule

/* dv/tb_superblock_checked_decoder.sv */
// Self-checking testbench for superblock_checked_decoder: header images in, field words out.
// Depends on sbcd_pkg for status codes, register indexes and header offsets.
`timescale 1ns / 1ps

module tb_superblock_checked_decoder;
  import sbcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int MAX_PRINTS = 40;
  localparam int IMG_LEN = 132;

  // corruptions applied to a generated image
  localparam int FLT_MAGIC = 1;
  localparam int FLT_CRC = 2;
  localparam int FLT_VER = 4;
  localparam int FLT_BSIZE = 8;
  localparam int FLT_ALL = 15;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND
  } fill_t;

  typedef struct packed {
    logic [7:0] data;
    logic start;
  } hdr_byte_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [63:0] value;
    sbcd_status_t status;
    logic last;
  } sb_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic [0:0]  s_tuser = '0;   // [0] block_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [4:0] field_index, [68:5] field_value, [71:69] zero
  logic [2:0]  m_tuser;        // [2:0] status
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  superblock_checked_decoder i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  hdr_byte_t  feed_q[$];
  sb_result_t expect_q[$];

  // register copies, written alongside the port writes
  logic [63:0] cfg_magic = '0;
  logic [31:0] cfg_ver_a = 32'd1;
  logic [31:0] cfg_ver_b = 32'd2;
  logic [31:0] cfg_bsize = 32'd4096;

  // decoder state as predicted
  int unsigned hdr_pos = POS_IDLE;
  logic [31:0] crc_acc = CRC_ONES;
  logic [31:0] crc_stored = '0;
  logic        magic_ok = 1'b1;
  logic [63:0] field_reg [NUM_FIELDS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ b[k]) ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  // advance the predicted header state by one word; queue results at the final byte
  function automatic void decode_byte(input hdr_byte_t w);
    int unsigned slot;
    int unsigned lane;
    logic [31:0] ver;
    logic [31:0] bsz;
    sbcd_status_t st;
    sb_result_t r;
    if (w.start) begin
      hdr_pos = 0;
      crc_acc = CRC_ONES;
      crc_stored = '0;
      magic_ok = 1'b1;
    end
    if (hdr_pos >= POS_IDLE) return;
    if (hdr_pos < MAGIC_LEN) begin
      if (cfg_magic[8*hdr_pos +: 8] != w.data) magic_ok = 1'b0;
    end
    if (hdr_pos < POS_CRC_SPAN) crc_acc = crc32_update(crc_acc, w.data);
    if (hdr_pos >= POS_FIELD_FIRST && hdr_pos < POS_CRC_SPAN) begin
      if (hdr_pos < 12) begin
        slot = 0; lane = hdr_pos - 8;
      end else if (hdr_pos < 16) begin
        slot = 1; lane = hdr_pos - 12;
      end else if (hdr_pos < 24) begin
        slot = 2; lane = hdr_pos - 16;
      end else if (hdr_pos < 28) begin
        slot = 3; lane = hdr_pos - 24;
      end else if (hdr_pos < 32) begin
        slot = 4; lane = hdr_pos - 28;
      end else begin
        slot = 5 + (hdr_pos - 32) / 8; lane = (hdr_pos - 32) % 8;
      end
      if (lane == 0) field_reg[slot] = '0;
      field_reg[slot][8*lane +: 8] = w.data;
    end
    if (hdr_pos >= POS_CRC_SPAN) crc_stored[8*(hdr_pos - POS_CRC_SPAN) +: 8] = w.data;
    hdr_pos++;
    if (hdr_pos != POS_IDLE) return;

    ver = field_reg[0][31:0];
    bsz = field_reg[1][31:0];
    if (!magic_ok) st = STS_BAD_MAGIC;
    else if ((crc_acc ^ CRC_ONES) != crc_stored) st = STS_BAD_CRC;
    else if (ver != cfg_ver_a && ver != cfg_ver_b) st = STS_BAD_VERSION;
    else if (bsz != cfg_bsize) st = STS_BAD_BLK_SIZE;
    else st = STS_OK;

    if (st != STS_OK) begin
      r.idx = '0; r.value = '0; r.status = st; r.last = 1'b1;
      expect_q.push_back(r);
    end else begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        r.idx = i[4:0]; r.value = field_reg[i]; r.status = STS_OK;
        r.last = (i == NUM_FIELDS - 1);
        expect_q.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic start);
    hdr_byte_t w;
    w.data = data;
    w.start = start;
    feed_q.push_back(w);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // an image cut short; the next start drops it
  task automatic queue_partial(input int n);
    push_byte(8'($urandom_range(255)), 1'b1);
    queue_noise(n - 1);
  endtask

  task automatic queue_image(input int faults, input fill_t fill, input bit use_b);
    logic [7:0] img [IMG_LEN];
    logic [31:0] crc;
    logic [31:0] ver;
    logic [31:0] bsz;
    int k;
    for (k = 0; k < MAGIC_LEN; k++) img[k] = cfg_magic[8*k +: 8];
    for (k = POS_FIELD_FIRST; k < IMG_LEN; k++) begin
      case (fill)
        FILL_ZERO: img[k] = 8'h00;
        FILL_ONES: img[k] = 8'hFF;
        default: img[k] = 8'($urandom_range(255));
      endcase
    end
    ver = use_b ? cfg_ver_b : cfg_ver_a;
    bsz = cfg_bsize;
    if ((faults & FLT_MAGIC) != 0) begin
      k = $urandom_range(MAGIC_LEN - 1);
      img[k] = img[k] ^ (8'h01 << $urandom_range(7));
    end
    // step off both allowed values
    if ((faults & FLT_VER) != 0) begin
      ver = (cfg_ver_a + 32'd1 == cfg_ver_b) ? cfg_ver_a + 32'd2 : cfg_ver_a + 32'd1;
    end
    if ((faults & FLT_BSIZE) != 0) bsz = cfg_bsize ^ (32'd1 << $urandom_range(31));
    for (k = 0; k < 4; k++) begin
      img[8 + k] = ver[8*k +: 8];
      img[12 + k] = bsz[8*k +: 8];
    end
    crc = CRC_ONES;
    for (k = 0; k < POS_CRC_SPAN; k++) crc = crc32_update(crc, img[k]);
    crc = crc ^ CRC_ONES;
    if ((faults & FLT_CRC) != 0) crc = crc ^ (32'd1 << $urandom_range(31));
    for (k = 0; k < 4; k++) img[POS_CRC_SPAN + k] = crc[8*k +: 8];
    for (k = 0; k < IMG_LEN; k++) push_byte(img[k], k == 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAGIC: cfg_magic = val;
      REG_VER_A: cfg_ver_a = val[31:0];
      REG_VER_B: cfg_ver_b = val[31:0];
      REG_BLK_SIZE: cfg_bsize = val[31:0];
      default: ;
    endcase
  endtask

  // upper halves of the 32-bit registers carry junk that must be dropped
  task automatic write_all(input logic [63:0] magic, input logic [31:0] ver_a,
                           input logic [31:0] ver_b, input logic [31:0] bsize);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VER_A, {32'($urandom), ver_a});
    write_reg(REG_VER_B, {32'($urandom), ver_b});
    write_reg(REG_BLK_SIZE, {32'($urandom), bsize});
    @(negedge clk);
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || s_tvalid || expect_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int n_img, input int idle_pct, input int stall_pct);
    int r;
    int faults;
    fill_t fill;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_img) begin
      r = $urandom_range(9);
      if (r == 6) faults = 1 << $urandom_range(3);
      else if (r == 7) faults = $urandom_range(1, FLT_ALL);
      else faults = 0;
      fill = ($urandom_range(7) == 0) ? fill_t'($urandom_range(1)) : FILL_RAND;
      if (r == 8) queue_partial($urandom_range(1, IMG_LEN - 1));
      if (r == 9) queue_noise($urandom_range(1, 6));
      queue_image(faults, fill, 1'($urandom_range(1)));
      if (r == 9) queue_noise($urandom_range(1, 6));
    end
    drain();
  endtask

  // sender: offer the head of feed_q, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(feed_q[0]);
        void'(feed_q.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= feed_q[0].data;
          s_tuser <= feed_q[0].start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold once armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done && m_tvalid) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    sb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: index %0d status %0d",
                                  m_tdata[4:0], m_tuser));
      end else begin
        want = expect_q.pop_front();
        if (m_tdata[4:0] !== want.idx)
          report_mismatch($sformatf("field_index %0d, want %0d", m_tdata[4:0], want.idx));
        if (m_tdata[68:5] !== want.value)
          report_mismatch($sformatf("field_value %h, want %h (index %0d)",
                                    m_tdata[68:5], want.value, want.idx));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b (index %0d)", m_tlast, want.last,
                                    want.idx));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[superblock_checked_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no idling, on the reset register values; the long receiver hold lands here
    // while the trailing noise keeps the sender offering
    hold_armed = 1'b1;
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    queue_partial(3);
    queue_image(0, FILL_RAND, 1'b0);
    queue_noise(4);
    drain();

    write_all('1, 32'd0, 32'hFFFF_FFFF, 32'd0);
    random_phase(1, 53, 0);
    write_all('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'($urandom));
    random_phase(1, 0, 53);
    write_all({32'($urandom), 32'($urandom)}, 32'($urandom), 32'($urandom), 32'($urandom));
    random_phase(1, 24, 24);

    if (expect_q.size() != 0) report_mismatch("results still outstanding at end of run");
    if (mismatch_count == 0) begin
      $display("[superblock_checked_decoder] OK");
    end else begin
      $display("[superblock_checked_decoder] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sbcd_pkg.sv
design/sbcd_regs.sv
design/sbcd_dp.sv
design/sbcd_ctrl.sv
design/superblock_checked_decoder.sv
dv/tb_superblock_checked_decoder.sv
